// ----- rtl/dos_wildcard_entry_filter_assert.svh -----
// Assertion macros for the wildcard entry filter.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef DOS_WILDCARD_ENTRY_FILTER_ASSERT_SVH
`define DOS_WILDCARD_ENTRY_FILTER_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is held.
`define DWEF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wildcard filter assertion failed");
// Next-cycle implication, disabled while reset is held.
`define DWEF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wildcard filter assertion failed");
`else
`define DWEF_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define DWEF_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/dwef_pkg.sv -----
// Shared constants, types and functions of the wildcard entry filter.
// Used by dwef_cell and dos_wildcard_entry_filter; depends on nothing.
package dwef_pkg;

    localparam int MAX_PATTERN_DEF = 12;
    localparam int PAT_STORED      = 12;
    localparam int PAT_HALF        = 6;
    localparam int CHAR_W          = 8;
    localparam int CFG_DATA_W      = 48;
    localparam int CFG_IDX_W       = 2;
    localparam int PAT_LEN_W       = 4;
    localparam int ATTR_W          = 8;

    localparam logic [CHAR_W-1:0] STAR_CHAR = 8'h2A;
    localparam logic [CHAR_W-1:0] ANY_CHAR  = 8'h3F;
    localparam logic [ATTR_W-1:0] SPECIAL_ATTR_MASK = 8'h16;

    localparam logic [CFG_IDX_W-1:0] CFG_PAT_FIRST = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LAST  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOWN     = 2'd3;

    // Per-word controls broadcast to every cell.
    typedef struct packed {
        logic present;
        logic reload;
        logic update;
    } t_step_ctl;

    // Signals handed from one cell to the next.
    typedef struct packed {
        logic adv;
        logic carry;
        logic scarry;
    } t_link;

    // Upper-case folding of a to z only.
    function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c >= 8'h61 && c <= 8'h7A) begin
            r = c - 8'h20;
        end
        return r;
    endfunction

endpackage

// ----- rtl/dwef_cell.sv -----
// One pattern position of the wildcard filter: holds its live bit and start bit.
// Depends on dwef_pkg for the link types and case folding.
module dwef_cell (
    input  logic                         i_clk,
    input  logic [dwef_pkg::CHAR_W-1:0]  i_pat_char,
    input  logic                         i_active,
    input  logic [dwef_pkg::CHAR_W-1:0]  i_name_fc,
    input  dwef_pkg::t_step_ctl          i_ctl,
    input  dwef_pkg::t_link              i_link,
    output dwef_pkg::t_link              o_link,
    output logic                         o_next
);
    import dwef_pkg::*;

    logic [CHAR_W-1:0] w_pc;
    logic w_star, w_hit, w_eff, w_raw, n_live, n_start;
    logic r_live, r_start;

    assign w_pc   = fold_case(i_pat_char);
    assign w_star = (w_pc == STAR_CHAR);
    assign w_hit  = (w_pc == ANY_CHAR) || (w_pc == i_name_fc);

    // After a last word or a register write the live set restarts from the start set.
    assign w_eff  = i_ctl.reload ? r_start : r_live;

    // A star keeps its own position alive; the previous cell may advance into this one.
    assign w_raw  = i_ctl.present ? ((w_eff & i_active & w_star) | i_link.adv) : w_eff;
    assign n_live = w_raw | i_link.carry;
    assign n_start = i_link.scarry;

    assign o_link.adv    = i_ctl.present & w_eff & i_active & ~w_star & w_hit;
    assign o_link.carry  = n_live & i_active & w_star;
    assign o_link.scarry = n_start & i_active & w_star;
    assign o_next        = n_live;

    always_ff @(posedge i_clk) begin
        r_start <= n_start;
        if (i_ctl.update) begin
            r_live <= n_live;
        end
    end

endmodule

// ----- rtl/dos_wildcard_entry_filter.sv -----
// Top level of the wildcard entry filter: configuration, cell chain, output register.
// Depends on dwef_pkg, dwef_cell and dos_wildcard_entry_filter_assert.svh.
//
//  Channel  | Direction | Handshake                 | Contents
//  s_axis   | in        | tvalid / tready           | one name character per word
//  m_axis   | out       | tvalid / tready           | match result, one word per name
//  cfg      | in        | wr_en, no back-pressure   | pattern, length, attribute mask
//
// Input words may follow back to back while the input is not stalled.
// The result of a name appears in the output register in the cycle after its last word.
// The critical path is the combinational star-closure ripple through the chain of position cells.
// Reset is synchronous and active low; the input is stalled in the cycle after reset
// and after every register write while the cells rebuild their start set.
// A stalled output word holds; the input keeps flowing if the result is being taken.
`include "dos_wildcard_entry_filter_assert.svh"
module dos_wildcard_entry_filter #(
    parameter int MAX_PATTERN = dwef_pkg::MAX_PATTERN_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // tdata: name_char [7:0], entry_attributes [15:8]
    input  logic [15:0]                    i_s_axis_tdata,
    // tuser: char_present [0]
    input  logic                           i_s_axis_tuser,
    input  logic                           i_s_axis_tlast,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // tdata: name_matched [0], visible [1], zero fill [7:2]
    output logic [7:0]                     o_m_axis_tdata,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    input  logic                           i_cfg_wr_en,
    input  logic [dwef_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [dwef_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import dwef_pkg::*;

    localparam int LW = $clog2(MAX_PATTERN + 1);
    localparam int CW = (LW > PAT_LEN_W) ? LW : PAT_LEN_W;
    localparam int NCELL = MAX_PATTERN + 1;

    // Configuration registers.
    logic [CFG_DATA_W-1:0] r_pat_first, r_pat_last;
    logic [PAT_LEN_W-1:0]  r_pat_len;
    logic [ATTR_W-1:0]     r_shown;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_first <= '0;
            r_pat_last  <= '0;
            r_pat_len   <= PAT_LEN_W'(1);
            r_shown     <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_PAT_FIRST: r_pat_first <= i_cfg_data;
                CFG_PAT_LAST:  r_pat_last  <= i_cfg_data;
                CFG_PAT_LEN:   r_pat_len   <= i_cfg_data[PAT_LEN_W-1:0];
                CFG_SHOWN:     r_shown     <= i_cfg_data[ATTR_W-1:0];
                default:       r_shown     <= r_shown;
            endcase
        end
    end

    // Pattern length saturated to the number of pattern cells.
    logic [CW-1:0] w_len_ext;
    logic [LW-1:0] w_len;
    assign w_len_ext = CW'(r_pat_len);
    assign w_len = (w_len_ext > CW'(MAX_PATTERN)) ? LW'(MAX_PATTERN) : LW'(w_len_ext);

    // Handshake and sequencing control.
    logic r_cfg_wait, r_reload, r_out_valid;
    logic [1:0] r_out_data;
    logic w_in_fire, w_last_fire;
    t_step_ctl w_ctl;

    assign o_s_axis_tready = ~r_cfg_wait & (~r_out_valid | i_m_axis_tready);
    assign w_in_fire   = i_s_axis_tvalid & o_s_axis_tready;
    assign w_last_fire = w_in_fire & i_s_axis_tlast;

    assign w_ctl.present = i_s_axis_tuser;
    assign w_ctl.reload  = r_reload;
    assign w_ctl.update  = w_in_fire;

    // The chain of position cells. The cell at the end position is never active;
    // it only stores whether the whole pattern has been consumed.
    t_link          w_link [NCELL+1];
    logic [NCELL-1:0] w_next;
    logic [CHAR_W-1:0] w_name_fc;

    assign w_name_fc = fold_case(i_s_axis_tdata[CHAR_W-1:0]);
    assign w_link[0] = '{adv: 1'b0, carry: 1'b0, scarry: 1'b1};

    for (genvar gi = 0; gi < NCELL; gi++) begin : g_cell
        logic [CHAR_W-1:0] w_pat_char;
        logic              w_active;

        if (gi < PAT_HALF) begin : g_lo
            assign w_pat_char = r_pat_first[gi*CHAR_W +: CHAR_W];
        end else if (gi < PAT_STORED) begin : g_hi
            assign w_pat_char = r_pat_last[(gi-PAT_HALF)*CHAR_W +: CHAR_W];
        end else begin : g_zero
            assign w_pat_char = '0;
        end

        assign w_active = (LW'(gi) < w_len);

        dwef_cell u_cell (
            .i_clk      (i_clk),
            .i_pat_char (w_pat_char),
            .i_active   (w_active),
            .i_name_fc  (w_name_fc),
            .i_ctl      (w_ctl),
            .i_link     (w_link[gi]),
            .o_link     (w_link[gi+1]),
            .o_next     (w_next[gi])
        );
    end

    // The name matches when the end position of the used pattern is live.
    logic w_matched, w_visible;
    assign w_matched = w_next[w_len];
    assign w_visible = w_matched &
        ((i_s_axis_tdata[15:8] & SPECIAL_ATTR_MASK & ~r_shown) == '0);

    logic n_cfg_wait, n_reload, n_out_valid;
    always_comb begin
        n_cfg_wait = i_cfg_wr_en;
        n_reload   = r_reload;
        if (i_cfg_wr_en || w_last_fire) begin
            n_reload = 1'b1;
        end else if (w_in_fire) begin
            n_reload = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (w_last_fire) begin
            n_out_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_wait  <= 1'b1;
            r_reload    <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_cfg_wait  <= n_cfg_wait;
            r_reload    <= n_reload;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_last_fire) begin
            r_out_data <= {w_visible, w_matched};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'b0, r_out_data};

    // A register write always stalls the input in the following cycle.
    `DWEF_ASSERT_NXT(a_cfg_stall, i_clk, i_rst_n, i_cfg_wr_en, !o_s_axis_tready)
    // An accepted last word always produces a result in the next cycle.
    `DWEF_ASSERT_NXT(a_last_result, i_clk, i_rst_n, w_last_fire, o_m_axis_tvalid)
    // A word that is not last never creates a result on its own.
    `DWEF_ASSERT_NXT(a_no_spurious, i_clk, i_rst_n,
        w_in_fire && !i_s_axis_tlast && !(o_m_axis_tvalid && !i_m_axis_tready),
        !o_m_axis_tvalid)
    // Visibility is never reported for a name that does not match.
    `DWEF_ASSERT_IMP(a_vis_match, i_clk, i_rst_n, o_m_axis_tvalid,
        !(o_m_axis_tdata[1] && !o_m_axis_tdata[0]))

endmodule
